/* rtl/core/dirty_switch_command_scheduler_core_defines.svh */
// Assertion macros for the dirty switch command scheduler
`ifndef DIRTY_SWITCH_COMMAND_SCHEDULER_CORE_DEFINES_SVH
`define DIRTY_SWITCH_COMMAND_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DSCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dscs_pkg.sv */
// Package: types and constants of the dirty switch command scheduler
`timescale 1ns / 1ps
package dscs_pkg;

   localparam int DECODERS = 4;
   localparam int CHANNELS = 6;
   localparam int ENTRIES  = DECODERS * CHANNELS;
   localparam int DEC_W    = (DECODERS > 1) ? $clog2(DECODERS) : 1;
   localparam int ENT_W    = $clog2(ENTRIES);
   localparam int CH_W     = 3;
   localparam int NUM_W    = 3;

   localparam logic [7:0]  REFRESH_MARK    = 8'h21;
   localparam logic [15:0] STAGGER_RESET   = 16'd100;
   localparam logic [7:0]  UNKNOWN_RESET   = 8'd0;
   localparam logic [2:0]  ID_DEC_MASK_LSB = 3'd4;

   typedef enum logic [1:0] {
      REQ_SET   = 2'd0,
      REQ_POLL  = 2'd1,
      REQ_ARM   = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      SWEEP_IDLE    = 2'd0,
      SWEEP_ARMED   = 2'd1,
      SWEEP_RUNNING = 2'd2
   } sweep_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_TAIL
   } ctrl_state_type;

   typedef enum logic {
      CSR_STAGGER = 1'b0,
      CSR_UNKNOWN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic do_set;
      logic do_arm;
      logic do_clear;
      logic do_sweep;
      logic scan_start;
      logic next_ch;
      logic next_dec;
      logic issue;
      logic clear_dec;
      logic clear_any;
      logic emit;
   } dscs_cmd_type;

   typedef struct packed {
      req_kind_type req;
      logic         sweep_active;
      logic         any_dirty;
      logic         normal_early;
      logic         dec_dirty;
      logic         ch_dirty;
      logic         last_ch;
      logic         last_dec;
   } dscs_status_type;

endpackage

/* rtl/core/dirty_switch_command_scheduler_core.sv */
// An item is taken when start is high and busy low; it is captured, run in ST_EXEC, and
// its result is registered. A poll that scans dirty marks steps through the channels of
// each dirty decoder, skipping a clean one at once; after an issue it checks the channels
// after the issued one (ST_TAIL). One item at a time: start is taken once busy drops.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: registers return to 100 ms and code 0, all marks clear, positions read as code 0.
`timescale 1ns / 1ps
`include "dirty_switch_command_scheduler_core_defines.svh"
module dirty_switch_command_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_switch_id,
   input  logic [7:0]  req_position_in,
   input  logic [31:0] req_now_ms,
   output logic        rsp_strobe,
   output logic        rsp_has_command,
   output logic [2:0]  rsp_decoder_number,
   output logic [2:0]  rsp_channel_number,
   output logic [7:0]  rsp_position_out,
   output logic        rsp_forced_refresh,
   output logic        rsp_bad_id,
   output logic        rsp_blink_pulse,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dscs_pkg::*;

   logic [15:0]     stagger_ff;
   logic [7:0]      unknown_ff;
   logic            csr_write;
   csr_index_type   csr_sel;
   dscs_cmd_type    cmd;
   dscs_status_type status;
   logic            cmd_id_ok;
   logic            refresh_ok;

   // registers sit at byte addresses 0 and 4; low address bits are the byte offset
   assign csr_sel   = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stagger_ff <= STAGGER_RESET;
         unknown_ff <= UNKNOWN_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_STAGGER: stagger_ff <= pwdata[15:0];
            CSR_UNKNOWN: unknown_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_STAGGER: prdata = {16'd0, stagger_ff};
         CSR_UNKNOWN: prdata = {24'd0, unknown_ff};
         default:     prdata = '0;
      endcase
   end

   dscs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dscs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .stagger_period_ms  (stagger_ff),
      .unknown_code       (unknown_ff),
      .req_type           (req_type),
      .req_switch_id      (req_switch_id),
      .req_position_in    (req_position_in),
      .req_now_ms         (req_now_ms),
      .rsp_strobe         (rsp_strobe),
      .rsp_has_command    (rsp_has_command),
      .rsp_decoder_number (rsp_decoder_number),
      .rsp_channel_number (rsp_channel_number),
      .rsp_position_out   (rsp_position_out),
      .rsp_forced_refresh (rsp_forced_refresh),
      .rsp_bad_id         (rsp_bad_id),
      .rsp_blink_pulse    (rsp_blink_pulse)
   );

   assign cmd_id_ok  = (rsp_decoder_number != 3'd0) && (rsp_channel_number != 3'd0)
                    && (rsp_channel_number <= 3'(CHANNELS));
   assign refresh_ok = rsp_has_command && (rsp_position_out == REFRESH_MARK);

   `DSCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `DSCS_ASSERT_NOW(a_strobe_after_work, rsp_strobe, $past(busy), "result without work")
   `DSCS_ASSERT_NOW(a_cmd_in_range, rsp_has_command, cmd_id_ok, "command id out of range")
   `DSCS_ASSERT_NOW(a_refresh_mark, rsp_forced_refresh, refresh_ok, "refresh without marker")

endmodule

/* rtl/core/dscs_ctrl.sv */
// Controller: sequences set, arm, clear, sweep and the dirty scan
`timescale 1ns / 1ps
module dscs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  dscs_pkg::dscs_status_type status,
   output dscs_pkg::dscs_cmd_type    cmd
);
   import dscs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            cmd.emit = 1'b1;
            case (status.req)
               REQ_SET:   cmd.do_set   = 1'b1;
               REQ_ARM:   cmd.do_arm   = 1'b1;
               REQ_CLEAR: cmd.do_clear = 1'b1;
               REQ_POLL: begin
                  if (status.sweep_active) begin
                     cmd.do_sweep = 1'b1;
                  end else if (status.any_dirty && !status.normal_early) begin
                     cmd.emit       = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (!status.dec_dirty) begin
               if (status.last_dec) begin
                  cmd.clear_any = 1'b1;
                  cmd.emit      = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.next_dec = 1'b1;
               end
            end else if (status.ch_dirty) begin
               cmd.issue = 1'b1;
               cmd.emit  = 1'b1;
               if (status.last_ch) begin
                  cmd.clear_dec = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.next_ch = 1'b1;
                  state_in    = ST_TAIL;
               end
            end else if (status.last_ch) begin
               // stale decoder mark
               cmd.clear_dec = 1'b1;
               if (status.last_dec) begin
                  cmd.clear_any = 1'b1;
                  cmd.emit      = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.next_dec = 1'b1;
               end
            end else begin
               cmd.next_ch = 1'b1;
            end
         end
         ST_TAIL: begin
            // look for another dirty channel after the one just issued
            if (status.ch_dirty) begin
               state_in = ST_IDLE;
            end else if (status.last_ch) begin
               cmd.clear_dec = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.next_ch = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/dscs_datapath.sv */
// Datapath: position table, dirty marks, sweep state, rate limit and result registers
`timescale 1ns / 1ps
module dscs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  dscs_pkg::dscs_cmd_type     cmd,
   output dscs_pkg::dscs_status_type  status,
   input  logic [15:0]               stagger_period_ms,
   input  logic [7:0]                unknown_code,
   input  logic [1:0]                req_type,
   input  logic [7:0]                req_switch_id,
   input  logic [7:0]                req_position_in,
   input  logic [31:0]               req_now_ms,
   output logic                      rsp_strobe,
   output logic                      rsp_has_command,
   output logic [2:0]                rsp_decoder_number,
   output logic [2:0]                rsp_channel_number,
   output logic [7:0]                rsp_position_out,
   output logic                      rsp_forced_refresh,
   output logic                      rsp_bad_id,
   output logic                      rsp_blink_pulse
);
   import dscs_pkg::*;

   // captured item
   logic [1:0]  req_type_ff;
   logic [7:0]  switch_id_ff;
   logic [7:0]  position_ff;
   logic [31:0] now_ff;

   // table: entries not written since the last clear read as fill_ff
   logic [7:0]         pos_ff [ENTRIES];
   logic [ENTRIES-1:0] pos_valid_ff;
   logic [7:0]         fill_ff;

   logic [ENTRIES-1:0]  ch_dirty_ff;
   logic [DECODERS-1:0] dec_dirty_ff;
   logic                any_dirty_ff;

   sweep_mode_type   sweep_mode_ff;
   logic [DEC_W-1:0] sweep_dec_ff;
   logic [CH_W-1:0]  sweep_ch_ff;
   logic [31:0]      last_normal_ff;
   logic [31:0]      last_sweep_ff;

   logic [DEC_W-1:0] scan_dec_ff;
   logic [CH_W-1:0]  scan_ch_ff;

   // result registers
   logic       strobe_ff;
   logic       has_cmd_ff, has_cmd_in;
   logic [2:0] dec_num_ff, dec_num_in;
   logic [2:0] ch_num_ff, ch_num_in;
   logic [7:0] pos_out_ff, pos_out_in;
   logic       forced_ff, forced_in;
   logic       bad_ff, bad_in;
   logic       blink_ff, blink_in;

   logic [2:0]       id_dec, id_ch, id_dec_m1, id_ch_m1;
   logic             id_bad;
   logic [ENT_W-1:0] set_idx, scan_idx, rd_idx;
   logic [DEC_W-1:0] set_dec;
   logic [7:0]       rd_pos;
   logic             pos_changed, mark_dirty;
   logic [31:0]      normal_due, sweep_due;
   logic             normal_early, sweep_early;
   logic             sweep_wrap;
   logic [DEC_W-1:0] sw_dec;
   logic [CH_W-1:0]  sw_ch;
   logic             sw_last_ch, sw_last_dec;

   assign id_dec    = switch_id_ff[6:4];
   assign id_ch     = switch_id_ff[2:0];
   assign id_dec_m1 = id_dec - 3'd1;
   assign id_ch_m1  = id_ch - 3'd1;
   assign id_bad    = (id_dec == 3'd0) || (32'(id_dec) > DECODERS)
                   || (id_ch == 3'd0) || (32'(id_ch) > CHANNELS);
   assign set_dec   = DEC_W'(id_dec_m1);
   assign set_idx   = ENT_W'(ENT_W'(id_dec_m1) * ENT_W'(CHANNELS) + ENT_W'(id_ch_m1));
   assign scan_idx  = ENT_W'(ENT_W'(scan_dec_ff) * ENT_W'(CHANNELS) + ENT_W'(scan_ch_ff));

   // single read port shared by set and issue
   assign rd_idx = cmd.issue ? scan_idx : set_idx;
   assign rd_pos = pos_valid_ff[rd_idx] ? pos_ff[rd_idx] : fill_ff;

   assign pos_changed = !id_bad && (rd_pos != position_ff);
   assign mark_dirty  = pos_changed && (position_ff != unknown_code);

   // wrapping due time, compared unsigned
   assign normal_due   = last_normal_ff + {16'd0, stagger_period_ms};
   assign sweep_due    = last_sweep_ff + {16'd0, stagger_period_ms};
   assign normal_early = normal_due > now_ff;
   assign sweep_early  = sweep_due > now_ff;

   assign sweep_wrap  = (32'(sweep_dec_ff) >= DECODERS) || (32'(sweep_ch_ff) >= CHANNELS);
   assign sw_dec      = sweep_wrap ? '0 : sweep_dec_ff;
   assign sw_ch       = sweep_wrap ? '0 : sweep_ch_ff;
   assign sw_last_ch  = (sw_ch == CH_W'(CHANNELS - 1));
   assign sw_last_dec = (sw_dec == DEC_W'(DECODERS - 1));

   assign status.req          = req_kind_type'(req_type_ff);
   assign status.sweep_active = (sweep_mode_ff != SWEEP_IDLE);
   assign status.any_dirty    = any_dirty_ff;
   assign status.normal_early = normal_early;
   assign status.dec_dirty    = dec_dirty_ff[scan_dec_ff];
   assign status.ch_dirty     = ch_dirty_ff[scan_idx];
   assign status.last_ch      = (scan_ch_ff == CH_W'(CHANNELS - 1));
   assign status.last_dec     = (scan_dec_ff == DEC_W'(DECODERS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff  <= req_type;
         switch_id_ff <= req_switch_id;
         position_ff  <= req_position_in;
         now_ff       <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_set && pos_changed) begin
         pos_ff[set_idx] <= position_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff   <= '0;
         fill_ff        <= UNKNOWN_RESET;
         ch_dirty_ff    <= '0;
         dec_dirty_ff   <= '0;
         any_dirty_ff   <= 1'b0;
         sweep_mode_ff  <= SWEEP_IDLE;
         sweep_dec_ff   <= '0;
         sweep_ch_ff    <= '0;
         last_normal_ff <= '0;
         last_sweep_ff  <= '0;
         scan_dec_ff    <= '0;
         scan_ch_ff     <= '0;
      end else begin
         if (cmd.do_set && pos_changed) begin
            pos_valid_ff[set_idx] <= 1'b1;
            if (mark_dirty) begin
               ch_dirty_ff[set_idx]  <= 1'b1;
               dec_dirty_ff[set_dec] <= 1'b1;
               any_dirty_ff          <= 1'b1;
            end
         end
         if (cmd.do_clear) begin
            pos_valid_ff <= '0;
            fill_ff      <= unknown_code;
            ch_dirty_ff  <= '0;
            dec_dirty_ff <= '0;
            any_dirty_ff <= 1'b0;
         end
         if (cmd.do_arm) begin
            sweep_mode_ff <= SWEEP_ARMED;
            sweep_dec_ff  <= '0;
            sweep_ch_ff   <= '0;
         end
         if (cmd.do_sweep && !sweep_early) begin
            last_sweep_ff <= now_ff;
            if (sweep_mode_ff == SWEEP_ARMED) begin
               // first allowed poll only starts the sweep
               sweep_mode_ff <= SWEEP_RUNNING;
            end else if (sw_last_ch) begin
               sweep_ch_ff <= '0;
               if (sw_last_dec) begin
                  sweep_dec_ff  <= '0;
                  sweep_mode_ff <= SWEEP_IDLE;
               end else begin
                  sweep_dec_ff <= sw_dec + DEC_W'(1);
               end
            end else begin
               sweep_dec_ff <= sw_dec;
               sweep_ch_ff  <= sw_ch + CH_W'(1);
            end
         end
         if (cmd.scan_start) begin
            scan_dec_ff <= '0;
            scan_ch_ff  <= '0;
         end
         if (cmd.next_dec) begin
            scan_dec_ff <= scan_dec_ff + DEC_W'(1);
            scan_ch_ff  <= '0;
         end
         if (cmd.next_ch) begin
            scan_ch_ff <= scan_ch_ff + CH_W'(1);
         end
         if (cmd.issue) begin
            ch_dirty_ff[scan_idx] <= 1'b0;
            last_normal_ff        <= now_ff;
         end
         if (cmd.clear_dec) begin
            dec_dirty_ff[scan_dec_ff] <= 1'b0;
         end
         if (cmd.clear_any) begin
            any_dirty_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      has_cmd_in = 1'b0;
      dec_num_in = '0;
      ch_num_in  = '0;
      pos_out_in = '0;
      forced_in  = 1'b0;
      bad_in     = 1'b0;
      blink_in   = 1'b0;
      if (cmd.do_set) begin
         bad_in   = id_bad;
         blink_in = mark_dirty;
      end
      if (cmd.do_sweep && !sweep_early && (sweep_mode_ff != SWEEP_ARMED)) begin
         has_cmd_in = 1'b1;
         dec_num_in = NUM_W'(sw_dec) + NUM_W'(1);
         ch_num_in  = NUM_W'(sw_ch) + NUM_W'(1);
         pos_out_in = REFRESH_MARK;
         forced_in  = 1'b1;
      end
      if (cmd.issue) begin
         has_cmd_in = 1'b1;
         dec_num_in = NUM_W'(scan_dec_ff) + NUM_W'(1);
         ch_num_in  = NUM_W'(scan_ch_ff) + NUM_W'(1);
         pos_out_in = rd_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff  <= 1'b0;
         has_cmd_ff <= 1'b0;
         dec_num_ff <= '0;
         ch_num_ff  <= '0;
         pos_out_ff <= '0;
         forced_ff  <= 1'b0;
         bad_ff     <= 1'b0;
         blink_ff   <= 1'b0;
      end else begin
         strobe_ff  <= cmd.emit;
         has_cmd_ff <= has_cmd_in;
         dec_num_ff <= dec_num_in;
         ch_num_ff  <= ch_num_in;
         pos_out_ff <= pos_out_in;
         forced_ff  <= forced_in;
         bad_ff     <= bad_in;
         blink_ff   <= blink_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_has_command    = has_cmd_ff;
   assign rsp_decoder_number = dec_num_ff;
   assign rsp_channel_number = ch_num_ff;
   assign rsp_position_out   = pos_out_ff;
   assign rsp_forced_refresh = forced_ff;
   assign rsp_bad_id         = bad_ff;
   assign rsp_blink_pulse    = blink_ff;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the dirty switch command scheduler core
`timescale 1ns / 1ps
module tb;
   import dscs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          SETTLE      = 40;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   id;
      logic [7:0]   pos;
      logic [31:0]  now;
   } sw_item_type;

   typedef struct packed {
      logic       has_cmd;
      logic [2:0] dec;
      logic [2:0] ch;
      logic [7:0] pos;
      logic       forced;
      logic       bad_id;
      logic       blink;
   } sw_cmd_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_SET;
   logic [7:0]  req_switch_id = 8'h00;
   logic [7:0]  req_position_in = 8'h00;
   logic [31:0] req_now_ms = 32'h0;
   logic        rsp_strobe;
   logic        rsp_has_command;
   logic [2:0]  rsp_decoder_number;
   logic [2:0]  rsp_channel_number;
   logic [7:0]  rsp_position_out;
   logic        rsp_forced_refresh;
   logic        rsp_bad_id;
   logic        rsp_blink_pulse;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'h0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   dirty_switch_command_scheduler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_switch_id(req_switch_id),
      .req_position_in(req_position_in), .req_now_ms(req_now_ms),
      .rsp_strobe(rsp_strobe), .rsp_has_command(rsp_has_command),
      .rsp_decoder_number(rsp_decoder_number), .rsp_channel_number(rsp_channel_number),
      .rsp_position_out(rsp_position_out), .rsp_forced_refresh(rsp_forced_refresh),
      .rsp_bad_id(rsp_bad_id), .rsp_blink_pulse(rsp_blink_pulse),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // scheduler mirror
   logic [7:0]     pos_tbl [ENTRIES];
   bit             ch_dirty [ENTRIES];
   bit             dec_dirty [DECODERS];
   bit             any_dirty_m;
   sweep_mode_type sweep_st = SWEEP_IDLE;
   int             sw_dec = 0;
   int             sw_ch = 0;
   logic [31:0]    last_norm_ms = 32'h0;
   logic [31:0]    last_sweep_ms = 32'h0;
   logic [15:0]    stagger_cfg = STAGGER_RESET;
   logic [7:0]     unknown_cfg = UNKNOWN_RESET;

   sw_item_type pending_items [$];
   sw_cmd_type  expected_cmds [$];
   sw_item_type cur_item;
   int          idle_pct = 8;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic [31:0] stim_ms = 32'd1000;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void wipe_table();
      for (int i = 0; i < ENTRIES; i++) begin
         pos_tbl[i] = unknown_cfg;
         ch_dirty[i] = 1'b0;
      end
      for (int i = 0; i < DECODERS; i++) dec_dirty[i] = 1'b0;
      any_dirty_m = 1'b0;
   endfunction

   // wrapping 32-bit due time compared unsigned
   function automatic bit too_soon(logic [31:0] last, logic [31:0] now);
      logic [31:0] due;
      due = last + {16'h0, stagger_cfg};
      return due > now;
   endfunction

   function automatic sw_cmd_type schedule_step(sw_item_type it);
      sw_cmd_type r;
      int         d, c, k, idx;
      bit         found, keep, issued;
      r = '0;
      case (it.kind)
         REQ_SET: begin
            d = it.id[6:4];
            c = it.id[2:0];
            if (d < 1 || d > DECODERS || c < 1 || c > CHANNELS) begin
               r.bad_id = 1'b1;
            end else begin
               idx = (d - 1) * CHANNELS + (c - 1);
               if (pos_tbl[idx] != it.pos) begin
                  pos_tbl[idx] = it.pos;
                  if (it.pos != unknown_cfg) begin
                     ch_dirty[idx] = 1'b1;
                     dec_dirty[d - 1] = 1'b1;
                     any_dirty_m = 1'b1;
                     r.blink = 1'b1;
                  end
               end
            end
         end
         REQ_POLL: begin
            if (sweep_st != SWEEP_IDLE) begin
               if (!too_soon(last_sweep_ms, it.now)) begin
                  last_sweep_ms = it.now;
                  if (sweep_st == SWEEP_ARMED) begin
                     sweep_st = SWEEP_RUNNING;
                  end else begin
                     if (sw_dec >= DECODERS || sw_ch >= CHANNELS) begin
                        sw_dec = 0;
                        sw_ch = 0;
                     end
                     r.has_cmd = 1'b1;
                     r.dec = 3'(sw_dec + 1);
                     r.ch = 3'(sw_ch + 1);
                     r.pos = REFRESH_MARK;
                     r.forced = 1'b1;
                     sw_ch++;
                     if (sw_ch == CHANNELS) begin
                        sw_ch = 0;
                        sw_dec++;
                        if (sw_dec == DECODERS) begin
                           sw_dec = 0;
                           sweep_st = SWEEP_IDLE;
                        end
                     end
                  end
               end
            end else if (any_dirty_m && !too_soon(last_norm_ms, it.now)) begin
               issued = 1'b0;
               for (d = 0; d < DECODERS; d++) begin
                  if (!dec_dirty[d]) continue;
                  found = 1'b0;
                  for (c = 0; c < CHANNELS; c++) begin
                     if (ch_dirty[d * CHANNELS + c]) begin
                        found = 1'b1;
                        break;
                     end
                  end
                  // stale decoder mark
                  if (!found) begin
                     dec_dirty[d] = 1'b0;
                     continue;
                  end
                  r.has_cmd = 1'b1;
                  r.dec = 3'(d + 1);
                  r.ch = 3'(c + 1);
                  r.pos = pos_tbl[d * CHANNELS + c];
                  last_norm_ms = it.now;
                  ch_dirty[d * CHANNELS + c] = 1'b0;
                  keep = 1'b0;
                  for (k = c; k < CHANNELS; k++)
                     if (ch_dirty[d * CHANNELS + k]) keep = 1'b1;
                  if (!keep) dec_dirty[d] = 1'b0;
                  issued = 1'b1;
                  break;
               end
               if (!issued) any_dirty_m = 1'b0;
            end
         end
         REQ_ARM: begin
            sweep_st = SWEEP_ARMED;
            sw_dec = 0;
            sw_ch = 0;
         end
         REQ_CLEAR: wipe_table();
         default: ;
      endcase
      return r;
   endfunction

   function automatic sw_item_type mk_item(req_kind_type k, logic [7:0] id, logic [7:0] pos,
                                           logic [31:0] now);
      sw_item_type it;
      it.kind = k;
      it.id = id;
      it.pos = pos;
      it.now = now;
      return it;
   endfunction

   function automatic void log_mismatch(string what, sw_cmd_type want, sw_cmd_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected cmd=%0d dec=%0d ch=%0d pos=%02h frc=%0d bad=%0d blk=%0d",
                  what, want.has_cmd, want.dec, want.ch, want.pos, want.forced,
                  want.bad_id, want.blink);
      if (mismatch_count <= 10)
         $display("   actual   cmd=%0d dec=%0d ch=%0d pos=%02h frc=%0d bad=%0d blk=%0d",
                  got.has_cmd, got.dec, got.ch, got.pos, got.forced, got.bad_id, got.blink);
   endfunction

   // driver: holds an item until it is taken, predicts at the taking edge
   always @(posedge clock) begin : drive_proc
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_cmds.push_back(schedule_step(cur_item));
         if (!start || !busy) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               cur_item = pending_items.pop_front();
               start <= 1'b1;
               req_type <= cur_item.kind;
               req_switch_id <= cur_item.id;
               req_position_in <= cur_item.pos;
               req_now_ms <= cur_item.now;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_proc
      sw_cmd_type got;
      if (!reset && rsp_strobe) begin
         got.has_cmd = rsp_has_command;
         got.dec = rsp_decoder_number;
         got.ch = rsp_channel_number;
         got.pos = rsp_position_out;
         got.forced = rsp_forced_refresh;
         got.bad_id = rsp_bad_id;
         got.blink = rsp_blink_pulse;
         if (expected_cmds.size() == 0) log_mismatch("unexpected result", '0, got);
         else if (expected_cmds[0] !== got) log_mismatch("mismatch", expected_cmds[0], got);
         if (expected_cmds.size() != 0) void'(expected_cmds.pop_front());
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // sampled at the falling edge so the driver and monitor have settled
   task automatic drain();
      while (pending_items.size() != 0 || start || expected_cmds.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(idx) << 2;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_STAGGER: stagger_cfg = val[15:0];
         CSR_UNKNOWN: unknown_cfg = val[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // mostly valid sets and advancing polls, some noise
   task automatic queue_random(int count);
      int          roll;
      logic [7:0]  id, pos;
      logic [31:0] now;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         id = 8'($urandom());
         pos = 8'($urandom());
         now = $urandom();
         if (roll < 42) begin
            if ($urandom_range(0, 9) != 0)
               id = {1'($urandom_range(0, 1)), 3'($urandom_range(1, DECODERS)),
                     1'($urandom_range(0, 1)), 3'($urandom_range(1, CHANNELS))};
            case ($urandom_range(0, 9))
               0, 1, 2: pos = unknown_cfg;
               3, 4, 5, 6: pos = 8'($urandom_range(0, 3));
               default: ;
            endcase
            pending_items.push_back(mk_item(REQ_SET, id, pos, now));
         end else if (roll < 98) begin
            if ($urandom_range(0, 9) == 0) begin
               now = stim_ms - $urandom_range(0, 50);
            end else begin
               stim_ms = stim_ms + $urandom_range(0, 2 * int'(stagger_cfg) + 20);
               now = stim_ms;
            end
            pending_items.push_back(mk_item(REQ_POLL, id, pos, now));
         end else if (roll < 99) begin
            pending_items.push_back(mk_item(REQ_ARM, id, pos, now));
         end else begin
            pending_items.push_back(mk_item(REQ_CLEAR, id, pos, now));
         end
      end
   endtask

   task automatic run_phase(logic [15:0] stagger, logic [7:0] unk, int idle, int count);
      drain();
      csr_write(CSR_STAGGER, {16'h0, stagger});
      csr_write(CSR_UNKNOWN, {24'h0, unk});
      idle_pct = idle;
      queue_random(count);
   endtask

   initial begin
      wipe_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bad ids, repeats, unknown code, rate limit with wrap, sweep, clear
      idle_pct = 8;
      pending_items.push_back(mk_item(REQ_SET, 8'h00, 8'h01, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'hFF, 8'h01, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h17, 8'h01, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h10, 8'h01, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h11, 8'hFF, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h11, 8'hFF, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h99, 8'hAA, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h4E, 8'h80, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h12, 8'h05, 32'h0));
      pending_items.push_back(mk_item(REQ_SET, 8'h12, 8'h00, 32'h0));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd0));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd100));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd150));
      pending_items.push_back(mk_item(REQ_POLL, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd0));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd99));
      // all channels served: this poll drops the global mark
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd300));
      pending_items.push_back(mk_item(REQ_ARM, 8'h00, 8'h00, 32'h0));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd50));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd400));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd500));
      pending_items.push_back(mk_item(REQ_ARM, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd600));
      pending_items.push_back(mk_item(REQ_POLL, 8'h00, 8'h00, 32'd700));
      pending_items.push_back(mk_item(REQ_CLEAR, 8'h00, 8'h00, 32'h0));

      run_phase(16'd0, 8'hFF, 8, 170);
      run_phase(16'hFFFF, 8'h00, 71, 170);
      run_phase(16'($urandom_range(1, 300)), 8'($urandom()), 71, 170);
      // time base wraps partway through the last phase
      drain();
      stim_ms = 32'hFFFF_E000;
      run_phase(16'd100, REFRESH_MARK, 0, 170);

      drain();
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dscs_pkg.sv
rtl/core/dscs_ctrl.sv
rtl/core/dscs_datapath.sv
rtl/core/dirty_switch_command_scheduler_core.sv
verif/tb.sv
